@@ hw/rtl/cpel_pkg.sv @@
package cpel_pkg;

   // Width of the internal byte offset counter; it saturates at all ones
   localparam int OffsetBits = 24;

   localparam int ByteOffsetWidth = 24;
   localparam logic [ByteOffsetWidth-1:0] ByteOffsetMax = '1;

   // Constant pool tag codes
   localparam logic [7:0] TAG_UTF8          = 8'd1;
   localparam logic [7:0] TAG_INTEGER       = 8'd3;
   localparam logic [7:0] TAG_FLOAT         = 8'd4;
   localparam logic [7:0] TAG_LONG          = 8'd5;
   localparam logic [7:0] TAG_DOUBLE        = 8'd6;
   localparam logic [7:0] TAG_CLASS         = 8'd7;
   localparam logic [7:0] TAG_STRING        = 8'd8;
   localparam logic [7:0] TAG_FIELDREF      = 8'd9;
   localparam logic [7:0] TAG_METHODREF     = 8'd10;
   localparam logic [7:0] TAG_IMETHODREF    = 8'd11;
   localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;

   typedef enum logic [1:0] {
      PH_TAG    = 2'd0,
      PH_LEN_HI = 2'd1,
      PH_LEN_LO = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] pool_byte;
      logic       pool_start;
   } req_type;

   typedef struct packed {
      logic                       entry_start;
      logic [15:0]                entry_number;
      logic [7:0]                 entry_tag;
      logic [ByteOffsetWidth-1:0] byte_offset;
      logic                       found;
      logic                       unknown_tag;
   } rsp_type;

endpackage

@@ hw/rtl/cpel_parse.sv @@
module cpel_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  cpel_pkg::req_type        item,
   input  logic [15:0]              target,
   output cpel_pkg::rsp_type        result
);

   cpel_pkg::phase_type                phase_ff, phase_in, cur_phase;
   logic [15:0]                        bytes_left_ff, bytes_left_in, cur_bytes_left;
   logic [7:0]                         length_high_ff, length_high_in, cur_length_high;
   logic [7:0]                         tag_ff, tag_in, cur_tag;
   logic [15:0]                        count_ff, count_in, cur_count;
   logic [cpel_pkg::OffsetBits-1:0]    offset_ff, offset_in, cur_offset;
   logic                               found_done_ff, found_done_in, cur_found_done;
   logic                               long_ff, long_in, cur_long;

   logic        entry_end;
   logic        hit;
   logic        known;
   logic [15:0] body_left;
   logic [16:0] count_sum;
   logic [32:0] offset_wide;

   // A pool start restarts every counter before this byte is parsed
   always_comb begin
      if (item.pool_start) begin
         cur_phase       = cpel_pkg::PH_TAG;
         cur_bytes_left  = '0;
         cur_length_high = '0;
         cur_tag         = '0;
         cur_count       = '0;
         cur_offset      = '0;
         cur_found_done  = 1'b0;
         cur_long        = 1'b0;
      end else begin
         cur_phase       = phase_ff;
         cur_bytes_left  = bytes_left_ff;
         cur_length_high = length_high_ff;
         cur_tag         = tag_ff;
         cur_count       = count_ff;
         cur_offset      = offset_ff;
         cur_found_done  = found_done_ff;
         cur_long        = long_ff;
      end
   end

   always_comb begin
      unique case (item.pool_byte)
         cpel_pkg::TAG_UTF8, cpel_pkg::TAG_INTEGER, cpel_pkg::TAG_FLOAT,
         cpel_pkg::TAG_LONG, cpel_pkg::TAG_DOUBLE, cpel_pkg::TAG_CLASS,
         cpel_pkg::TAG_STRING, cpel_pkg::TAG_FIELDREF, cpel_pkg::TAG_METHODREF,
         cpel_pkg::TAG_IMETHODREF, cpel_pkg::TAG_NAME_AND_TYPE: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign hit       = !cur_found_done && (cur_count >= target);
   assign body_left = (cur_bytes_left != '0) ? cur_bytes_left - 16'd1 : cur_bytes_left;

   // Next state
   always_comb begin
      phase_in       = cur_phase;
      bytes_left_in  = cur_bytes_left;
      length_high_in = cur_length_high;
      tag_in         = cur_tag;
      found_done_in  = cur_found_done;
      long_in        = cur_long;
      entry_end      = 1'b0;
      unique case (cur_phase)
         cpel_pkg::PH_TAG: begin
            tag_in  = item.pool_byte;
            long_in = 1'b0;
            if (hit) begin
               found_done_in = 1'b1;
            end
            unique case (item.pool_byte)
               cpel_pkg::TAG_CLASS, cpel_pkg::TAG_STRING: begin
                  bytes_left_in = 16'd2;
                  phase_in      = cpel_pkg::PH_BODY;
               end
               cpel_pkg::TAG_FIELDREF, cpel_pkg::TAG_METHODREF, cpel_pkg::TAG_IMETHODREF,
               cpel_pkg::TAG_INTEGER, cpel_pkg::TAG_FLOAT,
               cpel_pkg::TAG_NAME_AND_TYPE: begin
                  bytes_left_in = 16'd4;
                  phase_in      = cpel_pkg::PH_BODY;
               end
               cpel_pkg::TAG_LONG, cpel_pkg::TAG_DOUBLE: begin
                  bytes_left_in = 16'd8;
                  long_in       = 1'b1;
                  phase_in      = cpel_pkg::PH_BODY;
               end
               cpel_pkg::TAG_UTF8: begin
                  phase_in = cpel_pkg::PH_LEN_HI;
               end
               default: begin
                  entry_end = 1'b1;
                  phase_in  = cpel_pkg::PH_TAG;
               end
            endcase
         end
         cpel_pkg::PH_LEN_HI: begin
            length_high_in = item.pool_byte;
            phase_in       = cpel_pkg::PH_LEN_LO;
         end
         cpel_pkg::PH_LEN_LO: begin
            bytes_left_in = {cur_length_high, item.pool_byte};
            if ({cur_length_high, item.pool_byte} == 16'd0) begin
               entry_end = 1'b1;
               phase_in  = cpel_pkg::PH_TAG;
            end else begin
               phase_in = cpel_pkg::PH_BODY;
            end
         end
         cpel_pkg::PH_BODY: begin
            bytes_left_in = body_left;
            if (body_left == 16'd0) begin
               entry_end = 1'b1;
               phase_in  = cpel_pkg::PH_TAG;
            end
         end
         default: begin
            phase_in = cpel_pkg::PH_TAG;
         end
      endcase
   end

   // Saturating counters; the entry step uses the width flag as it stands after the tag
   assign count_sum = {1'b0, cur_count} + (long_in ? 17'd2 : 17'd1);
   always_comb begin
      count_in = cur_count;
      if (entry_end) begin
         count_in = count_sum[16] ? 16'hFFFF : count_sum[15:0];
      end
   end

   assign offset_in = (cur_offset != '1) ? cur_offset + 1'b1 : cur_offset;

   // Outputs
   assign offset_wide = 33'(cur_offset);
   always_comb begin
      result.entry_start  = (cur_phase == cpel_pkg::PH_TAG);
      result.entry_number = cur_count;
      result.entry_tag    = (cur_phase == cpel_pkg::PH_TAG) ? item.pool_byte : cur_tag;
      result.byte_offset  = (offset_wide > 33'(cpel_pkg::ByteOffsetMax)) ?
                            cpel_pkg::ByteOffsetMax :
                            offset_wide[cpel_pkg::ByteOffsetWidth-1:0];
      result.found        = (cur_phase == cpel_pkg::PH_TAG) && hit;
      result.unknown_tag  = (cur_phase == cpel_pkg::PH_TAG) && !known;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= cpel_pkg::PH_TAG;
         bytes_left_ff  <= '0;
         length_high_ff <= '0;
         tag_ff         <= '0;
         count_ff       <= '0;
         offset_ff      <= '0;
         found_done_ff  <= 1'b0;
         long_ff        <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         length_high_ff <= length_high_in;
         tag_ff         <= tag_in;
         count_ff       <= count_in;
         offset_ff      <= offset_in;
         found_done_ff  <= found_done_in;
         long_ff        <= long_in;
      end
   end

endmodule

@@ hw/rtl/class_constant_pool_entry_locator_top.sv @@
// Path: a word accepted on req loads the input register; when the rsp register is empty or
//   being drained, the parse logic result loads the rsp register, which drives rsp_valid.
// Throughput: one word per cycle; the input and rsp registers stall only on rsp_ready.
// Reset (synchronous, active high): both registers empty, parser expects a tag,
//   all counters zero and the target register zero.
module class_constant_pool_entry_locator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cpel_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpel_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   cpel_pkg::req_type in_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   cpel_pkg::rsp_type rsp_item_ff;
   logic [15:0]       target_ff;

   logic              advance;
   logic              step;
   cpel_pkg::rsp_type parse_result;

   // Advance the pipe whenever the rsp register is empty or being drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Parser state advances only when a word moves from the input register to rsp
   cpel_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .target (target_ff),
      .result (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            target_ff <= csr_wdata;
         end
      end
   end

   // Payload registers: the input register loads on acceptance, the rsp register on a step; both hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         rsp_item_ff <= parse_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_found_on_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.found |-> rsp_item.entry_start)
      else $error("found flagged on a non-tag word");

   a_unknown_on_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.unknown_tag |-> rsp_item.entry_start)
      else $error("unknown_tag flagged on a non-tag word");

   a_found_reaches_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.found |-> rsp_item.entry_number >= target_ff)
      else $error("found below the target entry");

   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipe not empty after reset");

endmodule
